// ===== src/isrm_pkg.sv =====
// ----------------------------------------------------------------------------
// isrm_pkg
// Shared types and codes for the Ising ring Metropolis block: operation codes,
// configuration register indexes, the input and result words, and the
// control word of the accumulation unit.
// ----------------------------------------------------------------------------
package isrm_pkg;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_FLIP    = 2'd1;
  localparam logic [1:0] OP_MEASURE = 2'd2;

  localparam logic [1:0] CFG_CHAIN_LENGTH   = 2'd0;
  localparam logic [1:0] CFG_FLIP_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_WARMUP_SWEEPS  = 2'd2;

  localparam int unsigned CFG_WIDTH = 32;
  localparam int unsigned LEN_WIDTH = 11;
  localparam int unsigned SUM_WIDTH = 12;

  typedef struct packed {
    logic [1:0]  operation;
    logic [9:0]  site;
    logic        spin_value;
    logic [31:0] random_draw;
  } in_word_t;

  typedef struct packed {
    logic                        flipped;
    logic signed [SUM_WIDTH-1:0] magnetization_sum;
    logic signed [SUM_WIDTH-1:0] energy_sum;
    logic                        product_negative;
    logic                        measurement_valid;
  } out_word_t;

  // one spin word handed to the accumulator per cycle of the ring walk
  typedef struct packed {
    logic take;
    logic first;
  } acc_ctl_t;

endpackage

// ===== src/isrm_ram.sv =====
// ----------------------------------------------------------------------------
// isrm_ram
// Generic single-write, single-read memory with registered read data. Read
// data holds while no read is issued.
// ----------------------------------------------------------------------------
module isrm_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/isrm_acc.sv =====
// ----------------------------------------------------------------------------
// isrm_acc
// Ring-walk accumulator: takes one spin per step and keeps the running
// magnetization, neighbor-pair energy and spin parity. The wraparound pair
// (last, first) is folded into the energy on the output side.
// ----------------------------------------------------------------------------
module isrm_acc #(
  parameter int unsigned ACW = 12
) (
  input  logic                  clk,
  input  isrm_pkg::acc_ctl_t    ctl,
  input  logic                  spin,
  output logic signed [ACW-1:0] mag,
  output logic signed [ACW-1:0] energy,
  output logic                  parity
);

  logic signed [ACW-1:0] mag_r, mag_nxt;
  logic signed [ACW-1:0] en_r, en_nxt;
  logic                  par_r, par_nxt;
  logic                  first_r, first_nxt;
  logic                  prev_r, prev_nxt;
  logic signed [ACW-1:0] spin_term;
  logic signed [ACW-1:0] pair_term;
  logic signed [ACW-1:0] wrap_term;

  // spin bit 1 means -1
  assign spin_term = spin ? -ACW'(1) : ACW'(1);
  // energy is minus the product of neighbors
  assign pair_term = (prev_r == spin) ? -ACW'(1) : ACW'(1);
  assign wrap_term = (prev_r == first_r) ? -ACW'(1) : ACW'(1);

  always_comb begin
    mag_nxt   = mag_r;
    en_nxt    = en_r;
    par_nxt   = par_r;
    first_nxt = first_r;
    prev_nxt  = prev_r;
    if (ctl.take) begin
      prev_nxt = spin;
      if (ctl.first) begin
        mag_nxt   = spin_term;
        en_nxt    = '0;
        par_nxt   = spin;
        first_nxt = spin;
      end else begin
        mag_nxt = mag_r + spin_term;
        en_nxt  = en_r + pair_term;
        par_nxt = par_r ^ spin;
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    en_r    <= en_nxt;
    par_r   <= par_nxt;
    first_r <= first_nxt;
    prev_r  <= prev_nxt;
  end

  assign mag    = mag_r;
  assign energy = en_r + wrap_term;
  assign parity = par_r;

endmodule

// ===== src/ising_ring_metropolis.sv =====
// sequence: load or unused code goes to S_QUICK; flip reads the site, its left and
//   right neighbors, then decides in S_F_DEC (to S_QUICK when the site is off the
//   ring); measure reads the n spins of the ring (one read per cycle), then S_M_TAIL, S_M_DONE
// one word at a time: the next word is taken once the result is registered
// reset: synchronous; a clearing pass then writes +1 to all MAX_SITES spins,
//   with in_ready low (config writes still taken)
// ----------------------------------------------------------------------------
// ising_ring_metropolis
// One-dimensional Ising ring with Metropolis flips. A small sequencer drives
// a one-bit spin memory, a shared 32-bit comparator and the ring-walk
// accumulator for loads, flip attempts and measurements.
// ----------------------------------------------------------------------------
module ising_ring_metropolis #(
  parameter int unsigned MAX_SITES = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  isrm_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output isrm_pkg::out_word_t             out_word,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [isrm_pkg::CFG_WIDTH-1:0]  cfg_wdata
);

  localparam int unsigned AW  = $clog2(MAX_SITES);
  localparam int unsigned NW0 = $clog2(MAX_SITES + 1);
  localparam int unsigned NW  = (NW0 > isrm_pkg::LEN_WIDTH) ? NW0 : isrm_pkg::LEN_WIDTH;
  localparam int unsigned ACW = (AW + 2 > isrm_pkg::SUM_WIDTH) ? AW + 2 : isrm_pkg::SUM_WIDTH;
  localparam logic signed [ACW-1:0] SAT_HI = ACW'(2047);
  localparam logic signed [ACW-1:0] SAT_LO = -ACW'(2048);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_QUICK,
    S_F_S,
    S_F_L,
    S_F_R,
    S_F_DEC,
    S_M_RD,
    S_M_TAIL,
    S_M_DONE
  } state_t;

  state_t                            state_r, state_nxt;
  isrm_pkg::in_word_t                item_r, item_nxt;
  logic [AW-1:0]                     cnt_r, cnt_nxt;
  logic                              s_r, s_nxt;
  logic                              l_r, l_nxt;
  logic [31:0]                       sweep_r, sweep_nxt;
  logic                              out_valid_r, out_valid_nxt;
  isrm_pkg::out_word_t               out_word_r, out_word_nxt;
  logic [isrm_pkg::LEN_WIDTH-1:0]    len_r, len_nxt;
  logic [31:0]                       thr_r, thr_nxt;
  logic [31:0]                       warm_r, warm_nxt;

  logic [NW-1:0]         len_x;
  logic [NW-1:0]         n_use;
  logic [NW-1:0]         site_x;
  logic [NW-1:0]         right_x;
  logic [NW-1:0]         left_x;
  logic [NW-1:0]         nm1_x;
  logic                  in_range;
  logic                  out_free;
  logic [31:0]           cmp_a;
  logic [31:0]           cmp_b;
  logic                  cmp_lt;
  logic                  all_same;
  logic                  accept;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic                  ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic                  ram_rdata;

  isrm_pkg::acc_ctl_t    acc_ctl;
  logic signed [ACW-1:0] acc_mag;
  logic signed [ACW-1:0] acc_en;
  logic                  acc_par;

  function automatic logic signed [isrm_pkg::SUM_WIDTH-1:0] sat_sum(
    input logic signed [ACW-1:0] v
  );
    logic signed [isrm_pkg::SUM_WIDTH-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[isrm_pkg::SUM_WIDTH-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[isrm_pkg::SUM_WIDTH-1:0];
    end else begin
      r = v[isrm_pkg::SUM_WIDTH-1:0];
    end
    return r;
  endfunction

  // ring length clamped to [2, MAX_SITES]
  always_comb begin
    len_x = NW'(len_r);
    if (len_x < NW'(2)) begin
      n_use = NW'(2);
    end else if (len_x > NW'(MAX_SITES)) begin
      n_use = NW'(MAX_SITES);
    end else begin
      n_use = len_x;
    end
  end

  assign site_x   = NW'(item_r.site);
  assign in_range = site_x < n_use;
  assign nm1_x    = n_use - NW'(1);
  assign right_x  = (site_x + NW'(1) < n_use) ? site_x + NW'(1) : '0;
  assign left_x   = (site_x == '0) ? nm1_x : site_x - NW'(1);
  assign out_free = !out_valid_r || out_ready;

  // shared comparator: acceptance draw during a flip, warm-up check on measure
  assign cmp_a  = (state_r == S_M_DONE) ? warm_r : item_r.random_draw;
  assign cmp_b  = (state_r == S_M_DONE) ? sweep_r : thr_r;
  assign cmp_lt = cmp_a < cmp_b;

  // uphill only when both neighbors match the spin (h = 2)
  assign all_same = (l_r == s_r) && (ram_rdata == s_r);
  assign accept   = !all_same || cmp_lt;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    s_nxt         = s_r;
    l_nxt         = l_r;
    sweep_nxt     = sweep_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    len_nxt       = len_r;
    thr_nxt       = thr_r;
    warm_nxt      = warm_r;
    ram_we        = 1'b0;
    ram_waddr     = site_x[AW-1:0];
    ram_wdata     = item_r.spin_value;
    ram_re        = 1'b0;
    ram_raddr     = site_x[AW-1:0];
    acc_ctl       = '0;

    if (cfg_we) begin
      case (cfg_index)
        isrm_pkg::CFG_CHAIN_LENGTH:   len_nxt  = cfg_wdata[isrm_pkg::LEN_WIDTH-1:0];
        isrm_pkg::CFG_FLIP_THRESHOLD: thr_nxt  = cfg_wdata;
        isrm_pkg::CFG_WARMUP_SWEEPS:  warm_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = 1'b0;
        cnt_nxt   = cnt_r + AW'(1);
        if (cnt_r == AW'(MAX_SITES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_word;
          cnt_nxt  = '0;
          case (in_word.operation)
            isrm_pkg::OP_FLIP:    state_nxt = S_F_S;
            isrm_pkg::OP_MEASURE: begin
              state_nxt = S_M_RD;
              if (sweep_r != '1) begin
                sweep_nxt = sweep_r + 32'd1;
              end
            end
            default:              state_nxt = S_QUICK;
          endcase
        end
      end
      S_QUICK: begin
        // load, unused code, or a flip whose site is off the ring
        if (out_free) begin
          ram_we        = (item_r.operation == isrm_pkg::OP_LOAD) && in_range;
          out_valid_nxt = 1'b1;
          out_word_nxt  = '0;
          state_nxt     = S_IDLE;
        end
      end
      S_F_S: begin
        if (!in_range) begin
          state_nxt = S_QUICK;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_F_L;
        end
      end
      S_F_L: begin
        ram_re    = 1'b1;
        ram_raddr = left_x[AW-1:0];
        s_nxt     = ram_rdata;
        state_nxt = S_F_R;
      end
      S_F_R: begin
        ram_re    = 1'b1;
        ram_raddr = right_x[AW-1:0];
        l_nxt     = ram_rdata;
        state_nxt = S_F_DEC;
      end
      S_F_DEC: begin
        if (out_free) begin
          ram_we               = accept;
          ram_wdata            = !s_r;
          out_valid_nxt        = 1'b1;
          out_word_nxt         = '0;
          out_word_nxt.flipped = accept;
          state_nxt            = S_IDLE;
        end
      end
      S_M_RD: begin
        ram_re        = 1'b1;
        ram_raddr     = cnt_r;
        // the accumulator takes the data of the read issued in the previous cycle
        acc_ctl.take  = cnt_r != '0;
        acc_ctl.first = cnt_r == AW'(1);
        cnt_nxt       = cnt_r + AW'(1);
        if (cnt_r == nm1_x[AW-1:0]) begin
          state_nxt = S_M_TAIL;
        end
      end
      S_M_TAIL: begin
        acc_ctl.take = 1'b1;
        state_nxt    = S_M_DONE;
      end
      S_M_DONE: begin
        if (out_free) begin
          out_valid_nxt                  = 1'b1;
          out_word_nxt.flipped           = 1'b0;
          out_word_nxt.magnetization_sum = sat_sum(acc_mag);
          out_word_nxt.energy_sum        = sat_sum(acc_en);
          out_word_nxt.product_negative  = acc_par;
          out_word_nxt.measurement_valid = cmp_lt;
          state_nxt                      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
      len_r       <= isrm_pkg::LEN_WIDTH'(1024);
      thr_r       <= '0;
      warm_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
      len_r       <= len_nxt;
      thr_r       <= thr_nxt;
      warm_r      <= warm_nxt;
    end
    item_r     <= item_nxt;
    s_r        <= s_nxt;
    l_r        <= l_nxt;
    out_word_r <= out_word_nxt;
  end

  isrm_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SITES)
  ) u_spin_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  isrm_acc #(
    .ACW (ACW)
  ) u_acc (
    .clk    (clk),
    .ctl    (acc_ctl),
    .spin   (ram_rdata),
    .mag    (acc_mag),
    .energy (acc_en),
    .parity (acc_par)
  );

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("word taken before the spin clearing pass");

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in progress");

  a_sweep_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> sweep_r >= $past(sweep_r))
    else $error("sweep counter went backward");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_M_RD || state_r == S_M_TAIL || state_r == S_M_DONE) |-> !ram_we)
    else $error("spin written during a ring walk");
`endif

endmodule
